[design/time_window_trigger_clusterer_assert.svh]
// Assertion helpers shared by the clusterer RTL.
// Every macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef TIME_WINDOW_TRIGGER_CLUSTERER_ASSERT_SVH
`define TIME_WINDOW_TRIGGER_CLUSTERER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TWTC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TWTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/twtc_pkg.sv]
package twtc_pkg;

  // Defaults for the top-level parameters.
  localparam int STAT_FRAC_BITS_DEF = 16;
  localparam int TAG_WIDTH_DEF      = 32;

  // Fixed field widths.
  localparam int TIME_W      = 62;
  localparam int STAT_W      = 32;
  localparam int TAG_FIELD_W = 32;
  localparam int IDX_W       = 32;
  localparam int WIN_W       = 40;
  localparam int MODE_W      = 3;

  // Input stream data: end time, seven statistics and the tag, padded to bytes.
  localparam int IN_BITS   = TIME_W + 8 * STAT_W;
  localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;

  // Q16.16 input format, and the width at which a Q16.16 value overflows the score.
  localparam int Q16_FRAC = 16;
  localparam int Q16_OVF_W = 48;

  // The scale factor for the coherent SNR when the null statistic is zero.
  localparam int MEGA_W = 20;
  localparam logic [MEGA_W-1:0] MEGA = MEGA_W'(1000000);
  localparam int PROD_W = STAT_W + MEGA_W;

  // Configuration port.
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_ADDR_W  = 4;
  localparam int CFG_SEL_BIT = 3;
  localparam logic REG_WINDOW = 1'b0;
  localparam logic REG_MODE   = 1'b1;

  // Score selection codes.
  localparam logic [MODE_W-1:0] MODE_SNR        = 3'd0;
  localparam logic [MODE_W-1:0] MODE_EFF_SNR    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_INV_NULL   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SNR_NULL   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_AUTO_COH   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_CROSS_COH  = 3'd5;
  localparam logic [MODE_W-1:0] MODE_AUTO_NULL  = 3'd6;
  localparam logic [MODE_W-1:0] MODE_CROSS_NULL = 3'd7;

  // Statistics of one trigger as they enter the score unit.
  typedef struct packed {
    logic [STAT_W-1:0] snr;
    logic [STAT_W-1:0] eff_snr;
    logic [STAT_W-1:0] null_stat;
    logic [STAT_W-1:0] auto_coh_sq;
    logic [STAT_W-1:0] cross_coh_sq;
    logic [STAT_W-1:0] auto_null_sq;
    logic [STAT_W-1:0] cross_null_sq;
  } twtc_stats_t;

  // Request from the cluster sequencer to the score unit.
  typedef struct packed {
    logic              start;
    logic [MODE_W-1:0] mode;
  } twtc_req_t;

endpackage

[design/twtc_score.sv]
module twtc_score
  import twtc_pkg::*;
#(
  parameter int STAT_FRAC_BITS = STAT_FRAC_BITS_DEF,
  localparam int SCORE_W = 32 + STAT_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  twtc_req_t          req,
  input  twtc_stats_t        stats,
  output logic               done,
  output logic [SCORE_W-1:0] score
);

  localparam int DIV_W = SCORE_W;
  localparam int CNT_W = $clog2(DIV_W + 1);
  localparam int REM_W = STAT_W + 1;
  localparam int SH = (STAT_FRAC_BITS >= Q16_FRAC) ? (STAT_FRAC_BITS - Q16_FRAC)
                                                   : (Q16_FRAC - STAT_FRAC_BITS);
  localparam logic [DIV_W-1:0] INV_ONE = DIV_W'(1) << (Q16_FRAC + STAT_FRAC_BITS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_MUL  = 2'd2;

  logic [1:0]         st_r, st_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               done_r, done_nxt;
  logic [DIV_W-1:0]   quo_r, quo_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic [REM_W-1:0]   den_r, den_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic [SCORE_W-1:0] score_r, score_nxt;
  logic [REM_W:0]     shifted;
  logic               fits;
  logic [STAT_W-1:0]  ratio_num;
  logic               null_zero;

  // Q16.16 to saturated Q32.STAT_FRAC_BITS, truncating toward zero.
  function automatic logic [SCORE_W-1:0] conv_q16(input logic [PROD_W-1:0] v);
    logic [Q16_OVF_W-1:0] low;
    logic [SCORE_W-1:0]   res;
    low = v[Q16_OVF_W-1:0];
    if (|v[PROD_W-1:Q16_OVF_W]) begin
      res = '1;
    end else if (STAT_FRAC_BITS >= Q16_FRAC) begin
      res = SCORE_W'(low) << SH;
    end else begin
      res = SCORE_W'(low >> SH);
    end
    return res;
  endfunction

  // Numerator of the ratio modes.
  always_comb begin
    unique case (req.mode)
      MODE_SNR_NULL:  ratio_num = stats.snr;
      MODE_AUTO_COH:  ratio_num = stats.auto_coh_sq;
      MODE_CROSS_COH: ratio_num = stats.cross_coh_sq;
      MODE_AUTO_NULL: ratio_num = stats.auto_null_sq;
      default:        ratio_num = stats.cross_null_sq;
    endcase
  end

  assign null_zero = (stats.null_stat == '0);

  // One restoring step of the shared divider: shift in a dividend bit, compare, subtract.
  assign shifted = {rem_r, quo_r[DIV_W-1]};
  assign fits    = (shifted >= {1'b0, den_r});

  // Sequencer around the divider and the SNR scaling multiplier.
  always_comb begin
    st_nxt    = st_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    den_nxt   = den_r;
    prod_nxt  = prod_r;
    score_nxt = score_r;
    unique case (st_r)
      S_IDLE: begin
        if (req.start) begin
          unique case (req.mode)
            MODE_SNR: begin
              score_nxt = conv_q16(PROD_W'(stats.snr));
              done_nxt  = 1'b1;
            end
            MODE_EFF_SNR: begin
              score_nxt = conv_q16(PROD_W'(stats.eff_snr));
              done_nxt  = 1'b1;
            end
            MODE_INV_NULL: begin
              quo_nxt = INV_ONE;
              rem_nxt = '0;
              den_nxt = {1'b0, stats.null_stat} + REM_W'(1);
              cnt_nxt = CNT_W'(DIV_W);
              st_nxt  = S_DIV;
            end
            MODE_SNR_NULL: begin
              if (null_zero) begin
                prod_nxt = stats.snr * MEGA;
                st_nxt   = S_MUL;
              end else begin
                quo_nxt = DIV_W'(ratio_num) << STAT_FRAC_BITS;
                rem_nxt = '0;
                den_nxt = {1'b0, stats.null_stat};
                cnt_nxt = CNT_W'(DIV_W);
                st_nxt  = S_DIV;
              end
            end
            default: begin
              if (null_zero) begin
                score_nxt = '1;
                done_nxt  = 1'b1;
              end else begin
                quo_nxt = DIV_W'(ratio_num) << STAT_FRAC_BITS;
                rem_nxt = '0;
                den_nxt = {1'b0, stats.null_stat};
                cnt_nxt = CNT_W'(DIV_W);
                st_nxt  = S_DIV;
              end
            end
          endcase
        end
      end
      S_DIV: begin
        rem_nxt = fits ? REM_W'(shifted - {1'b0, den_r}) : shifted[REM_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], fits};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          score_nxt = {quo_r[DIV_W-2:0], fits};
          done_nxt  = 1'b1;
          st_nxt    = S_IDLE;
        end
      end
      S_MUL: begin
        score_nxt = conv_q16(prod_r);
        done_nxt  = 1'b1;
        st_nxt    = S_IDLE;
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    den_r   <= den_nxt;
    prod_r  <= prod_nxt;
    score_r <= score_nxt;
  end

  assign done  = done_r;
  assign score = score_r;

endmodule

[design/time_window_trigger_clusterer.sv]
// Channel  | Direction | Transaction content
// in_      | slave     | one trigger; last_item on in_tlast
// out_     | master    | one emitted cluster; final_cluster on out_tlast
// cfg_     | APB slave | window_ns at byte address 0, stat_mode at byte address 8
//
// A trigger passes the idle, compare and calculation states. The direct SNR scores
// and the zero-null cases need no further score state, scaling the SNR by 1e6 adds
// a multiply state, and a ratio is formed by the restoring divider in twtc_score,
// which retires one quotient bit per cycle. One or both emit states follow for clusters.
// A waiting result sits in the output register while the next trigger is taken.
// An output stall holds the block in its emit state until the register frees up.
// rst_n is synchronous; reset clears the control registers, the held trigger and the count.
`include "time_window_trigger_clusterer_assert.svh"

module time_window_trigger_clusterer
  import twtc_pkg::*;
#(
  parameter int STAT_FRAC_BITS = STAT_FRAC_BITS_DEF,
  parameter int TAG_WIDTH      = TAG_WIDTH_DEF,
  localparam int SCORE_W    = 32 + STAT_FRAC_BITS,
  localparam int OUT_BITS   = TAG_FIELD_W + TIME_W + SCORE_W + IDX_W,
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // end_time_ns, snr, eff_snr, null_stat, auto_coh_sq, cross_coh_sq,
  // auto_null_sq, cross_null_sq, event_tag
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tvalid,
  input  logic                  in_tlast,
  output logic                  in_tready,
  // out_tag, out_time_ns, out_statistic, cluster_index
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tvalid,
  output logic                  out_tlast,
  input  logic                  out_tready,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int TAG_W = (TAG_WIDTH < TAG_FIELD_W) ? TAG_WIDTH : TAG_FIELD_W;
  localparam int TAG_LSB = TIME_W + 7 * STAT_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CMP   = 3'd1;
  localparam logic [2:0] ST_CALC  = 3'd2;
  localparam logic [2:0] ST_EMIT1 = 3'd3;
  localparam logic [2:0] ST_EMIT2 = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic               holding_r, holding_nxt;
  logic [IDX_W-1:0]   cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [WIN_W-1:0]   window_r;
  logic [MODE_W-1:0]  mode_r;

  logic [TIME_W-1:0]  item_time_r;
  logic [TAG_W-1:0]   item_tag_r;
  logic               item_last_r;
  twtc_stats_t        stats_r;
  logic               in_win_r;

  logic [TIME_W-1:0]  held_time_r;
  logic [SCORE_W-1:0] held_score_r;
  logic [TAG_W-1:0]   held_tag_r;

  logic [TIME_W-1:0]  gap_time_r;
  logic [SCORE_W-1:0] gap_score_r;
  logic [TAG_W-1:0]   gap_tag_r;
  logic [IDX_W-1:0]   gap_idx_r;

  logic [TIME_W-1:0]  out_time_r;
  logic [SCORE_W-1:0] out_stat_r;
  logic [TAG_W-1:0]   out_tag_r;
  logic [IDX_W-1:0]   out_idx_r;
  logic               out_last_r;

  logic               in_acc;
  logic               slot_free;
  logic               cfg_wr;
  logic [TIME_W:0]    diff;
  twtc_req_t          score_req;
  logic               score_done;
  logic [SCORE_W-1:0] score_val;
  logic               calc_done;
  logic               gap;
  logic               take;
  logic               load_gap;
  logic               load_fin;

  // Configuration registers; a write completes on the access phase.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[CFG_SEL_BIT] == REG_MODE) ? CFG_DATA_W'(mode_r)
                                                           : CFG_DATA_W'(window_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
      mode_r   <= MODE_SNR;
    end else if (cfg_wr) begin
      if (cfg_paddr[CFG_SEL_BIT] == REG_MODE) begin
        mode_r <= cfg_pwdata[MODE_W-1:0];
      end else begin
        window_r <= cfg_pwdata[WIN_W-1:0];
      end
    end
  end

  // Handshakes.
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;

  // Score unit, started once the trigger has been captured.
  assign score_req.start = (state_r == ST_CMP);
  assign score_req.mode  = mode_r;

  twtc_score #(
    .STAT_FRAC_BITS(STAT_FRAC_BITS)
  ) u_score (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (score_req),
    .stats (stats_r),
    .done  (score_done),
    .score (score_val)
  );

  // Cluster decision when the score arrives.
  assign calc_done = (state_r == ST_CALC) && score_done;
  assign gap       = holding_r && !in_win_r;
  assign take      = !holding_r || gap || (score_val > held_score_r);

  // Time distance to the held trigger; a borrow means the new one is earlier.
  assign diff = {1'b0, item_time_r} - {1'b0, held_time_r};

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    holding_nxt   = holding_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    load_gap      = 1'b0;
    load_fin      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        state_nxt = ST_CALC;
      end
      ST_CALC: begin
        if (score_done) begin
          holding_nxt = 1'b1;
          if (gap) begin
            cnt_nxt   = (cnt_r == '1) ? cnt_r : cnt_r + IDX_W'(1);
            state_nxt = ST_EMIT1;
          end else if (item_last_r) begin
            state_nxt = ST_EMIT2;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_EMIT1: begin
        if (slot_free) begin
          load_gap      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = item_last_r ? ST_EMIT2 : ST_IDLE;
        end
      end
      ST_EMIT2: begin
        if (slot_free) begin
          load_fin      = 1'b1;
          out_valid_nxt = 1'b1;
          holding_nxt   = 1'b0;
          cnt_nxt       = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      holding_r   <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      holding_r   <= holding_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload: captured trigger, held trigger, pending gap cluster, output register.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_time_r           <= in_tdata[TIME_W-1:0];
      stats_r.snr           <= in_tdata[TIME_W +: STAT_W];
      stats_r.eff_snr       <= in_tdata[TIME_W + STAT_W +: STAT_W];
      stats_r.null_stat     <= in_tdata[TIME_W + 2 * STAT_W +: STAT_W];
      stats_r.auto_coh_sq   <= in_tdata[TIME_W + 3 * STAT_W +: STAT_W];
      stats_r.cross_coh_sq  <= in_tdata[TIME_W + 4 * STAT_W +: STAT_W];
      stats_r.auto_null_sq  <= in_tdata[TIME_W + 5 * STAT_W +: STAT_W];
      stats_r.cross_null_sq <= in_tdata[TIME_W + 6 * STAT_W +: STAT_W];
      item_tag_r            <= in_tdata[TAG_LSB +: TAG_W];
      item_last_r           <= in_tlast;
    end
    if (state_r == ST_CMP) begin
      in_win_r <= diff[TIME_W] || (diff[TIME_W-1:0] < TIME_W'(window_r));
    end
    if (calc_done) begin
      if (gap) begin
        gap_time_r  <= held_time_r;
        gap_score_r <= held_score_r;
        gap_tag_r   <= held_tag_r;
        gap_idx_r   <= cnt_r;
      end
      if (take) begin
        held_time_r  <= item_time_r;
        held_score_r <= score_val;
        held_tag_r   <= item_tag_r;
      end
    end
    if (load_gap) begin
      out_time_r <= gap_time_r;
      out_stat_r <= gap_score_r;
      out_tag_r  <= gap_tag_r;
      out_idx_r  <= gap_idx_r;
      out_last_r <= 1'b0;
    end else if (load_fin) begin
      out_time_r <= held_time_r;
      out_stat_r <= held_score_r;
      out_tag_r  <= held_tag_r;
      out_idx_r  <= cnt_r;
      out_last_r <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = OUT_DATA_W'({out_idx_r, out_stat_r, out_time_r,
                                   TAG_FIELD_W'(out_tag_r)});

  // The final cluster ends the list: nothing held, count back at zero.
  `TWTC_ASSERT_NEXT(a_final_clears, state_r == ST_EMIT2 && slot_free,
    !holding_r && cnt_r == '0 && out_valid_r && out_last_r,
    "final cluster did not clear the held state")
  // A score only comes back while the sequencer waits for it.
  `TWTC_ASSERT_NOW(a_done_in_calc, score_done, state_r == ST_CALC,
    "score unit finished outside the calculation state")
  // Emission always has a trigger held.
  `TWTC_ASSERT_NOW(a_emit_holding, state_r == ST_EMIT1 || state_r == ST_EMIT2, holding_r,
    "emitting a cluster with nothing held")

endmodule

[dv/tb_time_window_trigger_clusterer.sv]
module tb_time_window_trigger_clusterer;
  timeunit 1ns;
  timeprecision 1ps;
  import twtc_pkg::*;

  localparam int SCORE_W = 32 + STAT_FRAC_BITS_DEF;
  localparam int OUT_DATA_W = ((TAG_FIELD_W + TIME_W + SCORE_W + IDX_W + 7) / 8) * 8;
  localparam int FRAC_SHIFT = STAT_FRAC_BITS_DEF - Q16_FRAC;
  localparam logic [63:0] SCORE_MAX = (64'd1 << SCORE_W) - 64'd1;
  localparam logic [63:0] TIME_MAX = (64'd1 << TIME_W) - 64'd1;
  localparam logic [63:0] WIN_MAX = (64'd1 << WIN_W) - 64'd1;
  localparam logic [63:0] SNR_SCALE = 64'd1000000;
  localparam logic [CFG_ADDR_W-1:0] ADDR_WINDOW = CFG_ADDR_W'(REG_WINDOW) << CFG_SEL_BIT;
  localparam logic [CFG_ADDR_W-1:0] ADDR_MODE = CFG_ADDR_W'(REG_MODE) << CFG_SEL_BIT;
  localparam int ITEMS = 1200;
  localparam int PRESSURE_LIST = 12;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES = 80;
  localparam int QUIET_LIMIT = 4000;
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic [TIME_W-1:0]      stamp_ns;
    twtc_stats_t            stats;
    logic [TAG_FIELD_W-1:0] tag;
    logic                   last;
  } trigger_t;

  typedef struct packed {
    logic [TAG_FIELD_W-1:0] tag;
    logic [TIME_W-1:0]      stamp_ns;
    logic [SCORE_W-1:0]     score;
    logic [IDX_W-1:0]       index;
    logic                   fin;
  } cluster_t;

  // Tracks the held trigger and the clusters the block owes us.
  class cluster_tracker;
    logic [WIN_W-1:0]       window;
    logic [MODE_W-1:0]      mode;
    bit                     holding;
    logic [TIME_W-1:0]      held_time;
    logic [SCORE_W-1:0]     held_score;
    logic [TAG_FIELD_W-1:0] held_tag;
    logic [IDX_W-1:0]       emitted;
    cluster_t               pending_clusters[$];
    bit                     modes_seen[8];
    int                     mismatches;
    int                     triggers_seen;
    int                     clusters_checked;

    function new();
      window = '0;
      mode = MODE_SNR;
      holding = 1'b0;
      held_time = '0;
      held_score = '0;
      held_tag = '0;
      emitted = '0;
      mismatches = 0;
      triggers_seen = 0;
      clusters_checked = 0;
    endfunction

    function logic [63:0] clip(logic [63:0] v);
      return (v > SCORE_MAX) ? SCORE_MAX : v;
    endfunction

    // A ratio over the null statistic; a zero divisor gives the largest score.
    function logic [63:0] over_null(logic [STAT_W-1:0] num, logic [STAT_W-1:0] den);
      if (den == '0) return SCORE_MAX;
      return clip((64'(num) << STAT_FRAC_BITS_DEF) / 64'(den));
    endfunction

    function logic [63:0] trigger_score(trigger_t t);
      twtc_stats_t s;
      s = t.stats;
      case (mode)
        MODE_SNR:       return clip(64'(s.snr) << FRAC_SHIFT);
        MODE_EFF_SNR:   return clip(64'(s.eff_snr) << FRAC_SHIFT);
        MODE_INV_NULL: begin
          return clip((64'd1 << (Q16_FRAC + STAT_FRAC_BITS_DEF)) / (64'(s.null_stat) + 64'd1));
        end
        MODE_SNR_NULL: begin
          if (s.null_stat != '0) return over_null(s.snr, s.null_stat);
          return clip((64'(s.snr) * SNR_SCALE) << FRAC_SHIFT);
        end
        MODE_AUTO_COH:  return over_null(s.auto_coh_sq, s.null_stat);
        MODE_CROSS_COH: return over_null(s.cross_coh_sq, s.null_stat);
        MODE_AUTO_NULL: return over_null(s.auto_null_sq, s.null_stat);
        default:        return over_null(s.cross_null_sq, s.null_stat);
      endcase
    endfunction

    function void emit_held(bit fin);
      cluster_t c;
      c.tag = held_tag;
      c.stamp_ns = held_time;
      c.score = held_score;
      c.index = emitted;
      c.fin = fin;
      pending_clusters.push_back(c);
      if (emitted != '1) emitted++;
    endfunction

    // Called for every accepted trigger transaction.
    function void note_trigger(trigger_t t);
      logic [63:0] sc;
      bit inside_window;
      sc = trigger_score(t);
      triggers_seen++;
      modes_seen[mode] = 1'b1;
      inside_window = (t.stamp_ns < held_time) ||
                      ((64'(t.stamp_ns) - 64'(held_time)) < 64'(window));
      if (holding && inside_window) begin
        // Same cluster: only a strictly higher score takes over.
        if (sc > 64'(held_score)) begin
          held_time = t.stamp_ns;
          held_score = SCORE_W'(sc);
          held_tag = t.tag;
        end
      end else begin
        if (holding) emit_held(1'b0);
        holding = 1'b1;
        held_time = t.stamp_ns;
        held_score = SCORE_W'(sc);
        held_tag = t.tag;
      end
      // The end of a list flushes what is held and starts the count over.
      if (t.last) begin
        emit_held(1'b1);
        holding = 1'b0;
        emitted = '0;
      end
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("mismatch: %s", msg);
    endtask

    // Called for every accepted cluster transaction.
    task check_cluster(cluster_t got);
      cluster_t want;
      clusters_checked++;
      if (pending_clusters.size() == 0) begin
        report_mismatch($sformatf("unexpected cluster, tag 0x%h", got.tag));
        return;
      end
      want = pending_clusters.pop_front();
      if (got.tag !== want.tag)
        report_mismatch($sformatf("cluster %0d out_tag 0x%h, want 0x%h",
                                  clusters_checked, got.tag, want.tag));
      if (got.stamp_ns !== want.stamp_ns)
        report_mismatch($sformatf("cluster %0d out_time_ns 0x%h, want 0x%h",
                                  clusters_checked, got.stamp_ns, want.stamp_ns));
      if (got.score !== want.score)
        report_mismatch($sformatf("cluster %0d out_statistic 0x%h, want 0x%h",
                                  clusters_checked, got.score, want.score));
      if (got.index !== want.index)
        report_mismatch($sformatf("cluster %0d cluster_index %0d, want %0d",
                                  clusters_checked, got.index, want.index));
      if (got.fin !== want.fin)
        report_mismatch($sformatf("cluster %0d final_cluster %b, want %b",
                                  clusters_checked, got.fin, want.fin));
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  // end_time_ns, snr, eff_snr, null_stat, auto_coh_sq, cross_coh_sq,
  // auto_null_sq, cross_null_sq, event_tag
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tvalid;
  logic                  in_tlast;
  logic                  in_tready;
  // out_tag, out_time_ns, out_statistic, cluster_index
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tlast;
  logic                  out_tready;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  cluster_tracker tracker = new();
  bit             steady = 1'b0;
  bit             hold_off_req = 1'b0;
  int             items_sent = 0;
  int             lists = 0;
  int             reg_writes = 0;
  int             quiet_cycles = 0;
  logic [63:0]    cursor = '0;

  time_window_trigger_clusterer dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tvalid   (in_tvalid),
    .in_tlast    (in_tlast),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tvalid  (out_tvalid),
    .out_tlast   (out_tlast),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [IN_DATA_W-1:0] to_bus(trigger_t t);
    return IN_DATA_W'({t.tag, t.stats.cross_null_sq, t.stats.auto_null_sq,
                       t.stats.cross_coh_sq, t.stats.auto_coh_sq, t.stats.null_stat,
                       t.stats.eff_snr, t.stats.snr, t.stamp_ns});
  endfunction

  function automatic trigger_t from_bus(logic [IN_DATA_W-1:0] d, logic last);
    trigger_t t;
    t.stamp_ns = d[0 +: TIME_W];
    t.stats.snr = d[TIME_W +: STAT_W];
    t.stats.eff_snr = d[TIME_W + STAT_W +: STAT_W];
    t.stats.null_stat = d[TIME_W + 2 * STAT_W +: STAT_W];
    t.stats.auto_coh_sq = d[TIME_W + 3 * STAT_W +: STAT_W];
    t.stats.cross_coh_sq = d[TIME_W + 4 * STAT_W +: STAT_W];
    t.stats.auto_null_sq = d[TIME_W + 5 * STAT_W +: STAT_W];
    t.stats.cross_null_sq = d[TIME_W + 6 * STAT_W +: STAT_W];
    t.tag = d[TIME_W + 7 * STAT_W +: TAG_FIELD_W];
    t.last = last;
    return t;
  endfunction

  function automatic cluster_t to_cluster(logic [OUT_DATA_W-1:0] d, logic last);
    cluster_t c;
    c.tag = d[0 +: TAG_FIELD_W];
    c.stamp_ns = d[TAG_FIELD_W +: TIME_W];
    c.score = d[TAG_FIELD_W + TIME_W +: SCORE_W];
    c.index = d[TAG_FIELD_W + TIME_W + SCORE_W +: IDX_W];
    c.fin = last;
    return c;
  endfunction

  // Both channels are observed at the clock edge where a transaction completes.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) tracker.note_trigger(from_bus(in_tdata, in_tlast));
    if (rst_n && out_tvalid && out_tready) tracker.check_cluster(to_cluster(out_tdata, out_tlast));
  end

  // The run is stopped if neither channel moves a transaction for too long.
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("timeout: no transaction for %0d cycles, %0d clusters still owed",
               QUIET_LIMIT, tracker.pending_clusters.size());
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result receiver: random stalls, quiet stretches, and one long hold-off on request.
  initial begin : result_sink
    int stall;
    bit hold_done;
    hold_done = 1'b0;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_off_req && !hold_done) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      stall = steady ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [STAT_W-1:0] rand_stat();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 3) return '0;
    if (pick < 5) return '1;
    if (pick < 10) return STAT_W'($urandom_range(1, 1 << 20));
    return $urandom;
  endfunction

  // Mostly sorted times: steps inside the window, gaps past it, a few going back.
  function automatic logic [TIME_W-1:0] next_time();
    logic [63:0] win;
    int pick;
    win = 64'(tracker.window);
    pick = $urandom_range(0, 99);
    if (pick < 10) return TIME_W'(cursor - 64'($urandom_range(1, 1000)));
    if (pick < 70) cursor += (win == 0) ? 64'd0 : rand64() % win;
    else cursor += win + 64'($urandom_range(0, 1000));
    cursor &= TIME_MAX;
    return TIME_W'(cursor);
  endfunction

  function automatic trigger_t random_trigger(bit last);
    trigger_t t;
    t.stamp_ns = next_time();
    t.stats.snr = rand_stat();
    t.stats.eff_snr = rand_stat();
    t.stats.null_stat = rand_stat();
    t.stats.auto_coh_sq = rand_stat();
    t.stats.cross_coh_sq = rand_stat();
    t.stats.auto_null_sq = rand_stat();
    t.stats.cross_null_sq = rand_stat();
    t.tag = $urandom;
    t.last = last;
    return t;
  endfunction

  // The four ratio numerators share one value; the effective SNR follows the SNR.
  function automatic trigger_t directed_trigger(logic [63:0] t_ns, logic [STAT_W-1:0] snr,
                                                logic [STAT_W-1:0] null_stat,
                                                logic [STAT_W-1:0] num,
                                                logic [TAG_FIELD_W-1:0] tag, bit last);
    trigger_t t;
    t.stamp_ns = TIME_W'(t_ns);
    t.stats.snr = snr;
    t.stats.eff_snr = snr;
    t.stats.null_stat = null_stat;
    t.stats.auto_coh_sq = num;
    t.stats.cross_coh_sq = num;
    t.stats.auto_null_sq = num;
    t.stats.cross_null_sq = num;
    t.tag = tag;
    t.last = last;
    return t;
  endfunction

  task automatic send_trigger(trigger_t t);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata <= to_bus(t);
    in_tlast <= t.last;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!(in_tvalid && in_tready));
    items_sent++;
  endtask

  task automatic end_stream();
    in_tvalid <= 1'b0;
    lists++;
  endtask

  // Waits for every owed cluster, then for the block to finish a trigger that emits none.
  task automatic settle();
    while (tracker.pending_clusters.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr == ADDR_WINDOW) tracker.window = data[WIN_W-1:0];
    else tracker.mode = data[MODE_W-1:0];
    reg_writes++;
  endtask

  task automatic configure(logic [63:0] win, logic [63:0] mode_word);
    cfg_write(ADDR_WINDOW, win);
    cfg_write(ADDR_MODE, mode_word);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Receiver stops for a long stretch while the sender keeps offering triggers.
  task automatic pressure_run();
    configure(64'd0, 64'(MODE_SNR));
    steady = 1'b1;
    hold_off_req = 1'b1;
    for (int i = 0; i < 40; i++) begin
      cursor = (cursor + 64'd1) & TIME_MAX;
      send_trigger(directed_trigger(cursor, $urandom, $urandom, $urandom, $urandom, i == 39));
    end
    end_stream();
    settle();
  endtask

  initial begin : stimulus
    logic [MODE_W-1:0] sweep[6];
    logic [63:0] win;
    logic [MODE_W-1:0] mode;
    int len;
    bit close;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tlast <= 1'b0;
    in_tdata <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: zero window, so only earlier triggers join the held one.
    send_trigger(directed_trigger(64'd1000, 32'd5, '0, '0, 32'd1, 1'b0));
    send_trigger(directed_trigger(64'd900, 32'd9, '0, '0, 32'd2, 1'b0));
    send_trigger(directed_trigger(64'd900, 32'd9, '0, '0, 32'd3, 1'b0));
    send_trigger(directed_trigger(64'd0, '1, '1, '1, '1, 1'b0));
    send_trigger(directed_trigger(TIME_MAX, '0, '0, '0, '0, 1'b1));
    end_stream();
    settle();

    // All-ones writes are cut to the register widths: widest window, last ratio mode.
    configure('1, '1);
    send_trigger(directed_trigger(64'd5, 32'd1, '0, '0, 32'd10, 1'b0));
    send_trigger(directed_trigger(64'd6, 32'd1, '0, '1, 32'd11, 1'b0));
    send_trigger(directed_trigger(64'd7, 32'd1, '1, '1, 32'd12, 1'b0));
    end_stream();
    settle();

    // Mode change with a trigger held: its score stays as first computed.
    configure(WIN_MAX, 64'(MODE_INV_NULL));
    send_trigger(directed_trigger(64'd8, 32'd1, '0, '0, 32'd13, 1'b0));
    send_trigger(directed_trigger(WIN_MAX + 64'd4, 32'd1, '0, '0, 32'd14, 1'b0));
    send_trigger(directed_trigger(WIN_MAX + 64'd5, 32'd1, 32'd1, '0, 32'd15, 1'b1));
    end_stream();
    settle();

    // Each remaining mode once, with a zero null statistic first.
    sweep = '{MODE_SNR_NULL, MODE_AUTO_COH, MODE_CROSS_COH, MODE_AUTO_NULL,
              MODE_EFF_SNR, MODE_SNR};
    foreach (sweep[k]) begin
      configure(64'd100, 64'(sweep[k]));
      send_trigger(directed_trigger(64'(200 * k), '1, '0, 32'd3, 32'(20 + k), 1'b0));
      send_trigger(directed_trigger(64'(200 * k + 150), 32'h0003_8000, 32'h0000_c000,
                                    32'h0012_3456, 32'(40 + k), 1'b1));
      end_stream();
      settle();
    end

    // Random lists with random settings between them.
    while (items_sent < ITEMS) begin
      if (lists == PRESSURE_LIST) pressure_run();
      if ($urandom_range(0, 4) != 0) begin
        case ($urandom_range(0, 9))
          0:       win = 64'd0;
          1:       win = WIN_MAX;
          2:       win = rand64();
          default: win = 64'($urandom_range(1, 5000));
        endcase
        mode = MODE_W'($urandom_range(0, 7));
        configure(win, ($urandom_range(0, 4) == 0) ? 64'({rand64() >> MODE_W, mode})
                                                   : 64'(mode));
      end
      if ($urandom_range(0, 3) == 0) cursor = rand64() & TIME_MAX;
      steady = ($urandom_range(0, 3) == 0);
      len = $urandom_range(1, 25);
      close = ($urandom_range(0, 9) != 0);
      for (int i = 0; i < len; i++) send_trigger(random_trigger(close && i == len - 1));
      end_stream();
      settle();
    end

    $display("Run covered %0d triggers in %0d lists, %0d register writes, score modes:",
             tracker.triggers_seen, lists, reg_writes);
    $display("  %p; %0d clusters checked, %0d mismatches.",
             tracker.modes_seen, tracker.clusters_checked, tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
